### rtl/ordered_list_insert_delete_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Shared property shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg
// Types, codes and constants shared by the ordered list modules.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned ST_W         = 2;

  // Command codes; the remaining code is ignored and answered with a plain OK.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_POS  = 3'd5,
    CMD_READ     = 3'd6
  } oli_cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } oli_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } oli_in_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_out;
    logic                    last;
  } oli_out_t;

  typedef enum logic [2:0] {
    OLI_IDLE,
    OLI_DECODE,
    OLI_SHIFT_UP,
    OLI_SHIFT_DN,
    OLI_PUT,
    OLI_READ,
    OLI_REPLY
  } oli_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic plan;
    logic shift_up;
    logic shift_dn;
    logic put;
    logic del_end;
    logic emit_data;
    logic emit_reply;
  } oli_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reply_only;
    logic is_ins;
    logic is_del;
    logic is_read;
    logic need_move;
    logic up_more;
    logic dn_more;
    logic rd_last;
    logic out_free;
  } oli_sts_t;

endpackage

### rtl/oli_ctrl.sv
// ----------------------------------------------------------------------------
// oli_ctrl
// Sequencer that steps the datapath through one command at a time.
// ----------------------------------------------------------------------------
module oli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oli_pkg::oli_sts_t sts,
  output oli_pkg::oli_ctl_t ctl
);

  oli_pkg::oli_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oli_pkg::OLI_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oli_pkg::OLI_IDLE: begin
        if (in_valid) state_nxt = oli_pkg::OLI_DECODE;
      end
      oli_pkg::OLI_DECODE: begin
        if (sts.reply_only) begin
          state_nxt = oli_pkg::OLI_REPLY;
        end else if (sts.is_read) begin
          state_nxt = oli_pkg::OLI_READ;
        end else if (sts.is_ins) begin
          state_nxt = sts.need_move ? oli_pkg::OLI_SHIFT_UP : oli_pkg::OLI_PUT;
        end else begin
          state_nxt = sts.need_move ? oli_pkg::OLI_SHIFT_DN : oli_pkg::OLI_REPLY;
        end
      end
      oli_pkg::OLI_SHIFT_UP: begin
        if (!sts.up_more) state_nxt = oli_pkg::OLI_PUT;
      end
      oli_pkg::OLI_SHIFT_DN: begin
        if (!sts.dn_more) state_nxt = oli_pkg::OLI_REPLY;
      end
      oli_pkg::OLI_PUT: begin
        state_nxt = oli_pkg::OLI_REPLY;
      end
      oli_pkg::OLI_READ: begin
        if (sts.out_free && sts.rd_last) state_nxt = oli_pkg::OLI_IDLE;
      end
      oli_pkg::OLI_REPLY: begin
        if (sts.out_free) state_nxt = oli_pkg::OLI_IDLE;
      end
      default: state_nxt = oli_pkg::OLI_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      oli_pkg::OLI_IDLE: begin
        in_stall = !rst_n;
        ctl.load = in_valid;
      end
      oli_pkg::OLI_DECODE: begin
        ctl.plan    = 1'b1;
        ctl.del_end = sts.is_del && !sts.need_move;
      end
      oli_pkg::OLI_SHIFT_UP: begin
        ctl.shift_up = 1'b1;
      end
      oli_pkg::OLI_SHIFT_DN: begin
        ctl.shift_dn = 1'b1;
        ctl.del_end  = !sts.dn_more;
      end
      oli_pkg::OLI_PUT: begin
        ctl.put = 1'b1;
      end
      oli_pkg::OLI_READ: begin
        ctl.emit_data = sts.out_free;
      end
      oli_pkg::OLI_REPLY: begin
        ctl.emit_reply = sts.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

### rtl/oli_dpath.sv
// ----------------------------------------------------------------------------
// oli_dpath
// Entry memory, entry count, shift pointers and the output word register.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_top_assert.svh"

module oli_dpath #(
  parameter int unsigned CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  oli_pkg::oli_in_t  in_data,
  input  oli_pkg::oli_ctl_t ctl,
  output oli_pkg::oli_sts_t sts,
  input  logic              out_stall,
  output logic              out_valid,
  output oli_pkg::oli_out_t out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > oli_pkg::POS_W) ? CW : oli_pkg::POS_W) + 1;

  logic [oli_pkg::CMD_W-1:0]        cmd_r;
  logic signed [oli_pkg::VAL_W-1:0] val_r;
  logic [oli_pkg::POS_W-1:0]        pos_r;
  logic [CW-1:0]                    cnt_r;
  logic [AW-1:0]                    ptr_r;
  logic [AW-1:0]                    tgt_r;
  oli_pkg::oli_status_t             st_r;
  logic signed [oli_pkg::VAL_W-1:0] rd_q_r;
  logic [oli_pkg::VAL_W-1:0]        mem_r [CAPACITY];
  oli_pkg::oli_out_t                out_r;
  logic                             out_valid_r;

  logic [XW-1:0]        cnt_x, pos_x, ptr_x, tgt_x;
  logic [XW-1:0]        ins_idx_x, del_idx_x;
  logic                 full, empty, pos_bad_ins, pos_bad_del;
  logic                 ins_move, del_move;
  oli_pkg::oli_status_t dec_st;
  logic                 reply_only, is_ins, is_del, is_read;
  logic                 up_more, dn_more, rd_last;

  logic                      rd_en, wr_en;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic [oli_pkg::VAL_W-1:0] wr_data;

  assign cnt_x = XW'(cnt_r);
  assign pos_x = XW'(pos_r);
  assign ptr_x = XW'(ptr_r);
  assign tgt_x = XW'(tgt_r);

  // Command decode against the current fill.
  always_comb begin
    full        = (cnt_x == XW'(CAPACITY));
    empty       = (cnt_x == '0);
    pos_bad_ins = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    pos_bad_del = (pos_x == '0) || (pos_x > cnt_x);
    dec_st      = oli_pkg::ST_OK;
    reply_only  = 1'b0;
    is_ins      = 1'b0;
    is_del      = 1'b0;
    is_read     = 1'b0;
    if (cmd_r inside {oli_pkg::CMD_INS_HEAD, oli_pkg::CMD_INS_TAIL, oli_pkg::CMD_INS_POS}) begin
      if (full) begin
        dec_st     = oli_pkg::ST_FULL;
        reply_only = 1'b1;
      end else if ((cmd_r == oli_pkg::CMD_INS_POS) && pos_bad_ins) begin
        dec_st     = oli_pkg::ST_RANGE;
        reply_only = 1'b1;
      end else begin
        is_ins = 1'b1;
      end
    end else if (cmd_r inside {oli_pkg::CMD_DEL_HEAD, oli_pkg::CMD_DEL_TAIL,
                               oli_pkg::CMD_DEL_POS}) begin
      if (empty) begin
        dec_st     = oli_pkg::ST_EMPTY;
        reply_only = 1'b1;
      end else if ((cmd_r == oli_pkg::CMD_DEL_POS) && pos_bad_del) begin
        dec_st     = oli_pkg::ST_RANGE;
        reply_only = 1'b1;
      end else begin
        is_del = 1'b1;
      end
    end else if (cmd_r == oli_pkg::CMD_READ) begin
      if (empty) begin
        dec_st     = oli_pkg::ST_EMPTY;
        reply_only = 1'b1;
      end else begin
        is_read = 1'b1;
      end
    end else begin
      reply_only = 1'b1;
    end
  end

  always_comb begin
    case (cmd_r)
      oli_pkg::CMD_INS_HEAD: ins_idx_x = '0;
      oli_pkg::CMD_INS_TAIL: ins_idx_x = cnt_x;
      default:               ins_idx_x = pos_x - XW'(1);
    endcase
    case (cmd_r)
      oli_pkg::CMD_DEL_HEAD: del_idx_x = '0;
      oli_pkg::CMD_DEL_TAIL: del_idx_x = cnt_x - XW'(1);
      default:               del_idx_x = pos_x - XW'(1);
    endcase
  end

  assign ins_move = (cnt_x > ins_idx_x);
  assign del_move = (del_idx_x + XW'(1) < cnt_x);
  assign up_more  = (ptr_x > tgt_x + XW'(1));
  assign dn_more  = (ptr_x + XW'(2) < cnt_x);
  assign rd_last  = (ptr_x + XW'(1) == cnt_x);

  always_comb begin
    sts            = '0;
    sts.reply_only = reply_only;
    sts.is_ins     = is_ins;
    sts.is_del     = is_del;
    sts.is_read    = is_read;
    sts.need_move  = (is_ins && ins_move) || (is_del && del_move);
    sts.up_more    = up_more;
    sts.dn_more    = dn_more;
    sts.rd_last    = rd_last;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Memory port selection. A shift writes the word read in the cycle before
  // while it fetches the next one, so one entry moves per cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_q_r;
    if (ctl.plan) begin
      if (is_ins && ins_move) begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_x - XW'(1));
      end else if (is_del && del_move) begin
        rd_en   = 1'b1;
        rd_addr = AW'(del_idx_x + XW'(1));
      end else if (is_read) begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
    end
    if (ctl.shift_up) begin
      wr_en = 1'b1;
      if (up_more) begin
        rd_en   = 1'b1;
        rd_addr = ptr_r - AW'(2);
      end
    end
    if (ctl.shift_dn) begin
      wr_en = 1'b1;
      if (dn_more) begin
        rd_en   = 1'b1;
        rd_addr = ptr_r + AW'(2);
      end
    end
    if (ctl.put) begin
      wr_en   = 1'b1;
      wr_addr = tgt_r;
      wr_data = val_r;
    end
    if (ctl.emit_data && !rd_last) begin
      rd_en   = 1'b1;
      rd_addr = ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data.command;
      val_r <= in_data.value;
      pos_r <= in_data.position;
    end
    if (ctl.plan) begin
      st_r <= dec_st;
      if (is_ins) begin
        ptr_r <= AW'(cnt_x);
        tgt_r <= AW'(ins_idx_x);
      end else if (is_del) begin
        ptr_r <= AW'(del_idx_x);
      end else begin
        ptr_r <= '0;
      end
    end else if (ctl.shift_up) begin
      ptr_r <= ptr_r - AW'(1);
    end else if (ctl.shift_dn || (ctl.emit_data && !rd_last)) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (ctl.emit_data) begin
      out_r.status    <= oli_pkg::ST_OK;
      out_r.value_out <= rd_q_r;
      out_r.last      <= rd_last;
    end else if (ctl.emit_reply) begin
      out_r.status    <= st_r;
      out_r.value_out <= '0;
      out_r.last      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.put) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (ctl.del_end) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (ctl.emit_data || ctl.emit_reply) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `OLI_ASSERT_NOW(a_put_not_full, ctl.put, cnt_r < CW'(CAPACITY), "insert into a full list")
  `OLI_ASSERT_NOW(a_del_not_empty, ctl.del_end, cnt_r != '0, "delete from an empty list")
  `OLI_ASSERT_NOW(a_emit_free, ctl.emit_data || ctl.emit_reply, !out_valid_r || !out_stall, "output word overwritten while stalled")
  `OLI_ASSERT_NOW(a_shift_in_range, ctl.shift_up, ptr_r > tgt_r, "upward shift ran past the insert slot")

endmodule

### rtl/ordered_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// Bounded ordered list of signed 32-bit values with head, tail and
// positional insert and delete, and a full read out from head to tail.
// ----------------------------------------------------------------------------
// The list keeps up to CAPACITY entries in a memory with one read port and
// one write port, in order from head to tail, so every insert and delete
// moves the entries behind the chosen slot one place, one entry per clock.
// A command word is taken only while the block is idle. After it is taken,
// the block decodes it; an insert or delete that goes ahead then moves the
// entries between the chosen slot and the tail, an insert writes its value,
// and the single result word is loaded into the output register. A read
// out loads one word per cycle into the output register, from head to tail,
// while the consumer does not stall; an empty list answers with one word of
// status empty. Every command other than read out returns exactly one word,
// with last set. A full list, an empty list or a position outside the list
// is reported in the status field and leaves the contents untouched; the
// unused command code is answered with status OK. The result word sits in
// an output register, so the next command can be accepted while it waits.
// No clearing pass follows reset: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top #(
  parameter int unsigned CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oli_pkg::oli_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output oli_pkg::oli_out_t out_data
);

  // Commands and status between the sequencer and the datapath.
  oli_pkg::oli_ctl_t ctl;
  oli_pkg::oli_sts_t sts;

  // The sequencer holds off new words until the current command has
  // delivered its last result word to the output register.
  oli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath owns the entry memory, the fill count and the result word.
  oli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
